// ===== sv/etlu_pkg.sv =====
// etlu_pkg: constants, widths, opcodes and controller/datapath bundles
// for the tetrahedral eikonal local update block; no dependencies
package etlu_pkg;

   localparam int GRID_STEPS = 15;
   localparam int STEPS_W    = $clog2(GRID_STEPS + 1);
   localparam int COORD_W    = 32;
   localparam int TIME_W     = 32;
   localparam int BEST_W     = 40;
   localparam int MAG_W      = COORD_W + STEPS_W;
   localparam int D_W        = MAG_W + 1;
   localparam int HALF_W     = (MAG_W + 1) / 2;
   localparam int ROOT_W     = MAG_W + 1;
   localparam int RAD_W      = 2 * ROOT_W;
   localparam int REM_W      = ROOT_W + 3;
   localparam int SUM_W      = TIME_W + STEPS_W + 2;
   localparam int CNT_W      = $clog2(BEST_W);

   // divide by the grid step count through a reciprocal multiply
   localparam int DIV_SHIFT  = BEST_W + STEPS_W;
   localparam int DM_W       = DIV_SHIFT + 1;
   localparam int DM_HALF    = (DM_W + 1) / 2;
   localparam int DX_W       = BEST_W / 2;
   localparam int PROD_W     = BEST_W + DM_W;
   localparam int DIV_TERMS  = 4;
   localparam logic [DM_W-1:0] DIV_MULT =
      DM_W'(((64'd1 << DIV_SHIFT) + 64'(GRID_STEPS - 1)) / 64'(GRID_STEPS));

   localparam logic [1:0] OP_TARGET = 2'd0;
   localparam logic [1:0] OP_CORNER = 2'd1;
   localparam logic [1:0] OP_FINISH = 2'd2;
   localparam logic [1:0] SLOT_LAST = 2'd2;
   localparam logic [1:0] AX_LAST   = 2'd2;
   localparam logic [1:0] PP_LAST   = 2'd2;
   localparam logic [1:0] PP_LL     = 2'd0;
   localparam logic [1:0] PP_HL     = 2'd1;
   localparam logic [1:0] DP_LL     = 2'd0;
   localparam logic [1:0] DP_LH     = 2'd1;
   localparam logic [1:0] DP_HL     = 2'd2;

   typedef struct packed {
      logic               ld_target;
      logic               ld_corner;
      logic               diff;
      logic               start_sample;
      logic               pp;
      logic               sqrt_init;
      logic               sqrt_step;
      logic               update;
      logic               div_init;
      logic               div_step;
      logic               load_out;
      logic [1:0]         axis;
      logic [1:0]         pp_sel;
      logic [STEPS_W-1:0] i;
      logic [STEPS_W-1:0] j;
   } etlu_cmd_type;

   typedef struct packed {
      logic any_cell;
      logic out_busy;
   } etlu_sts_type;

endpackage

// ===== sv/eikonal_tet_local_update_top.sv =====
// eikonal_tet_local_update_top: top level joining controller and datapath
// depends on etlu_pkg, etlu_ctrl, etlu_dp
//
// usage
//   req channel: one beat per item; opcode 0 loads the target vertex and
//   clears the running minimum, opcode 1 loads a cell corner (slots 0..2,
//   slot 2 starts the sweep over the barycentric grid), opcode 2 asks for
//   the result; other codes and corner slot 3 are dropped
//   rsp channel: one beat per finish item with best_time and found
// sequencing
//   target and corner 0/1 items are taken straight from idle
//   a corner 2 item sweeps samples = (N+1)(N+2)/2 grid points, each with
//   a difference and 3 partial products per axis, a root init, sqrt_steps
//   = 33 + clog2(N+1) root steps at one bit a cycle, and an update;
//   N = 15 gives 136 samples; a finish item runs the 4 partial products
//   of the reciprocal multiply with a found cell, else skips them
// reset clears the target, the minimum and the found flag; no clearing pass
// a stalled result holds in the output register while further non-finish
// items are taken; a finish waits until that register is free
module eikonal_tet_local_update_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_opcode,
   input  logic [1:0]         req_corner,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic [31:0]        req_arrival_time,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [39:0]        rsp_best_time,
   output logic               rsp_found
);
   import etlu_pkg::*;

   etlu_cmd_type cmd;
   etlu_sts_type sts;

   etlu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .req_corner (req_corner),
      .sts        (sts),
      .cmd        (cmd)
   );

   etlu_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_corner       (req_corner),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_arrival_time (req_arrival_time),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_best_time    (rsp_best_time),
      .rsp_found        (rsp_found)
   );

endmodule

// ===== sv/etlu_dp.sv =====
// etlu_dp: datapath with vertex storage, distance and square units, bit-serial
// square root, reciprocal divider, running minimum and result register; uses etlu_pkg
module etlu_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  etlu_pkg::etlu_cmd_type      cmd,
   output etlu_pkg::etlu_sts_type      sts,
   input  logic [1:0]                  req_corner,
   input  logic signed [31:0]          req_pos_x,
   input  logic signed [31:0]          req_pos_y,
   input  logic signed [31:0]          req_pos_z,
   input  logic [31:0]                 req_arrival_time,
   input  logic                        rsp_stall,
   output logic                        rsp_valid,
   output logic [39:0]                 rsp_best_time,
   output logic                        rsp_found
);
   import etlu_pkg::*;

   logic signed [COORD_W-1:0] target_ff [3];
   logic signed [COORD_W-1:0] target_in [3];
   logic signed [COORD_W-1:0] corner_ff [3][3];
   logic signed [COORD_W-1:0] corner_in [3][3];
   logic [TIME_W-1:0]  ctime_ff [3];
   logic [TIME_W-1:0]  ctime_in [3];
   logic [BEST_W-1:0]  best_ff, best_in;
   logic               any_ff, any_in;
   logic [MAG_W-1:0]   mag_ff, mag_in;
   logic [RAD_W-1:0]   acc_ff, acc_in;
   logic [RAD_W-1:0]   rad_ff, rad_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [ROOT_W-1:0]  root_ff, root_in;
   logic [SUM_W-1:0]   tsum_ff, tsum_in;
   logic [PROD_W-1:0]  dacc_ff, dacc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BEST_W-1:0]  rsp_best_ff, rsp_best_in;
   logic               rsp_found_ff, rsp_found_in;

   logic [STEPS_W-1:0]     k;
   logic signed [D_W-1:0]  d;
   logic [HALF_W-1:0]      op_a, op_b;
   logic [2*HALF_W-1:0]    prod;
   logic [RAD_W-1:0]       addend;
   logic [REM_W-1:0]       rem_sh, trial;
   logic [DX_W-1:0]        dx;
   logic [DM_HALF-1:0]     dm;
   logic [DX_W+DM_HALF-1:0] dprod;
   logic [PROD_W-1:0]      dterm;
   logic [SUM_W-1:0]       s_sum;
   logic [BEST_W-1:0]      s_val;

   function automatic logic signed [D_W-1:0] wmul(logic [STEPS_W-1:0] w,
                                                   logic signed [COORD_W-1:0] c);
      logic signed [D_W-1:0] cw;
      logic signed [D_W-1:0] ww;
      cw = D_W'(c);
      ww = D_W'($signed({1'b0, w}));
      return cw * ww;
   endfunction

   function automatic logic [SUM_W-1:0] tmul(logic [STEPS_W-1:0] w,
                                            logic [TIME_W-1:0] t);
      logic [TIME_W+STEPS_W-1:0] p;
      p = w * t;
      return SUM_W'(p);
   endfunction

   always_comb begin
      k = STEPS_W'(GRID_STEPS) - cmd.i - cmd.j;
      d = wmul(STEPS_W'(GRID_STEPS), target_ff[cmd.axis])
        - (wmul(cmd.i, corner_ff[0][cmd.axis]) + wmul(cmd.j, corner_ff[1][cmd.axis])
           + wmul(k, corner_ff[2][cmd.axis]));

      case (cmd.pp_sel)
         PP_LL: begin
            op_a = mag_ff[HALF_W-1:0];
            op_b = mag_ff[HALF_W-1:0];
         end
         PP_HL: begin
            op_a = mag_ff[HALF_W-1:0];
            op_b = HALF_W'(mag_ff[MAG_W-1:HALF_W]);
         end
         default: begin
            op_a = HALF_W'(mag_ff[MAG_W-1:HALF_W]);
            op_b = HALF_W'(mag_ff[MAG_W-1:HALF_W]);
         end
      endcase
      prod = op_a * op_b;
      case (cmd.pp_sel)
         PP_LL:   addend = RAD_W'(prod);
         PP_HL:   addend = RAD_W'(prod) << (HALF_W + 1);
         default: addend = RAD_W'(prod) << (2 * HALF_W);
      endcase

      rem_sh = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1:RAD_W-2]};
      trial  = {1'b0, root_ff, 2'b01};

      // one partial product of minimum times reciprocal per cycle
      case (cmd.pp_sel)
         DP_LL: begin
            dx = best_ff[DX_W-1:0];
            dm = DIV_MULT[DM_HALF-1:0];
         end
         DP_LH: begin
            dx = best_ff[DX_W-1:0];
            dm = DM_HALF'(DIV_MULT[DM_W-1:DM_HALF]);
         end
         DP_HL: begin
            dx = best_ff[BEST_W-1:DX_W];
            dm = DIV_MULT[DM_HALF-1:0];
         end
         default: begin
            dx = best_ff[BEST_W-1:DX_W];
            dm = DM_HALF'(DIV_MULT[DM_W-1:DM_HALF]);
         end
      endcase
      dprod = dx * dm;
      case (cmd.pp_sel)
         DP_LL:   dterm = PROD_W'(dprod);
         DP_LH:   dterm = PROD_W'(dprod) << DM_HALF;
         DP_HL:   dterm = PROD_W'(dprod) << DX_W;
         default: dterm = PROD_W'(dprod) << (DX_W + DM_HALF);
      endcase

      s_sum = tsum_ff + SUM_W'(root_ff);
      s_val = BEST_W'(s_sum);
   end

   always_comb begin
      target_in    = target_ff;
      corner_in    = corner_ff;
      ctime_in     = ctime_ff;
      best_in      = best_ff;
      any_in       = any_ff;
      mag_in       = mag_ff;
      acc_in       = acc_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      tsum_in      = tsum_ff;
      dacc_in      = dacc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_best_in  = rsp_best_ff;
      rsp_found_in = rsp_found_ff;

      if (cmd.ld_target) begin
         target_in[0] = req_pos_x;
         target_in[1] = req_pos_y;
         target_in[2] = req_pos_z;
         best_in      = '1;
         any_in       = 1'b0;
      end
      if (cmd.ld_corner) begin
         corner_in[req_corner][0] = req_pos_x;
         corner_in[req_corner][1] = req_pos_y;
         corner_in[req_corner][2] = req_pos_z;
         ctime_in[req_corner]     = req_arrival_time;
         if (req_corner == SLOT_LAST) begin
            any_in = 1'b1;
         end
      end
      if (cmd.diff) begin
         mag_in = d[D_W-1] ? MAG_W'(-d) : MAG_W'(d);
         if (cmd.start_sample) begin
            acc_in = '0;
         end
      end
      if (cmd.pp) begin
         acc_in = acc_ff + addend;
      end
      if (cmd.sqrt_init) begin
         rad_in  = acc_ff;
         rem_in  = '0;
         root_in = '0;
         tsum_in = tmul(cmd.i, ctime_ff[0]) + tmul(cmd.j, ctime_ff[1]) + tmul(k, ctime_ff[2]);
      end
      if (cmd.sqrt_step) begin
         rad_in = rad_ff << 2;
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
      if (cmd.update && (s_val < best_ff)) begin
         best_in = s_val;
      end
      if (cmd.div_init) begin
         dacc_in = '0;
      end
      if (cmd.div_step) begin
         dacc_in = dacc_ff + dterm;
      end
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         rsp_best_in  = any_ff ? dacc_ff[DIV_SHIFT +: BEST_W] : '1;
         rsp_found_in = any_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= '{default: '0};
         best_ff      <= '1;
         any_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         target_ff    <= target_in;
         best_ff      <= best_in;
         any_ff       <= any_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      corner_ff    <= corner_in;
      ctime_ff     <= ctime_in;
      mag_ff       <= mag_in;
      acc_ff       <= acc_in;
      rad_ff       <= rad_in;
      rem_ff       <= rem_in;
      root_ff      <= root_in;
      tsum_ff      <= tsum_in;
      dacc_ff      <= dacc_in;
      rsp_best_ff  <= rsp_best_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign sts.any_cell  = any_ff;
   assign sts.out_busy  = rsp_valid_ff && rsp_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_best_time = rsp_best_ff;
   assign rsp_found     = rsp_found_ff;

endmodule

// ===== sv/etlu_ctrl.sv =====
// etlu_ctrl: controller state machine sequencing sample sweep, square root
// and divide steps over the datapath; uses etlu_pkg
module etlu_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_opcode,
   input  logic [1:0]             req_corner,
   input  etlu_pkg::etlu_sts_type sts,
   output etlu_pkg::etlu_cmd_type cmd
);
   import etlu_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DIFF   = 3'd1;
   localparam logic [2:0] S_MUL    = 3'd2;
   localparam logic [2:0] S_SQINIT = 3'd3;
   localparam logic [2:0] S_SQRT   = 3'd4;
   localparam logic [2:0] S_UPDATE = 3'd5;
   localparam logic [2:0] S_DIV    = 3'd6;
   localparam logic [2:0] S_LOAD   = 3'd7;

   logic [2:0]         state_ff, state_in;
   logic [1:0]         axis_ff, axis_in;
   logic [1:0]         pp_ff, pp_in;
   logic [CNT_W-1:0]   step_ff, step_in;
   logic [STEPS_W-1:0] i_ff, i_in;
   logic [STEPS_W-1:0] j_ff, j_in;
   logic [STEPS_W-1:0] j_max;

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      pp_in    = pp_ff;
      step_in  = step_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      j_max    = STEPS_W'(GRID_STEPS) - i_ff;
      cmd      = '0;
      cmd.axis   = axis_ff;
      cmd.pp_sel = pp_ff;
      cmd.i      = i_ff;
      cmd.j      = j_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_opcode)
                  OP_TARGET: cmd.ld_target = 1'b1;
                  OP_CORNER: begin
                     if (req_corner inside {[2'd0:SLOT_LAST]}) begin
                        cmd.ld_corner = 1'b1;
                     end
                     if (req_corner == SLOT_LAST) begin
                        i_in     = '0;
                        j_in     = '0;
                        axis_in  = '0;
                        state_in = S_DIFF;
                     end
                  end
                  OP_FINISH: begin
                     cmd.div_init = 1'b1;
                     step_in      = '0;
                     state_in     = sts.any_cell ? S_DIV : S_LOAD;
                  end
                  default: ;
               endcase
            end
         end
         S_DIFF: begin
            cmd.diff         = 1'b1;
            cmd.start_sample = axis_ff == 2'd0;
            pp_in            = '0;
            state_in         = S_MUL;
         end
         S_MUL: begin
            cmd.pp = 1'b1;
            if (pp_ff == PP_LAST) begin
               if (axis_ff == AX_LAST) begin
                  state_in = S_SQINIT;
               end else begin
                  axis_in  = axis_ff + 2'd1;
                  state_in = S_DIFF;
               end
            end else begin
               pp_in = pp_ff + 2'd1;
            end
         end
         S_SQINIT: begin
            cmd.sqrt_init = 1'b1;
            step_in       = '0;
            state_in      = S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (step_ff == CNT_W'(ROOT_W - 1)) begin
               state_in = S_UPDATE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            axis_in    = '0;
            state_in   = S_DIFF;
            if (j_ff == j_max) begin
               j_in = '0;
               if (i_ff == STEPS_W'(GRID_STEPS)) begin
                  i_in     = '0;
                  state_in = S_IDLE;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cmd.pp_sel   = step_ff[1:0];
            if (step_ff == CNT_W'(DIV_TERMS - 1)) begin
               state_in = S_LOAD;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_LOAD: begin
            if (!sts.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         axis_ff  <= '0;
         pp_ff    <= '0;
         step_ff  <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         pp_ff    <= pp_in;
         step_ff  <= step_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;

`ifndef SYNTHESIS
   a_sqrt_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SQRT) |-> (step_ff <= CNT_W'(ROOT_W - 1)))
      else $error("square root step count overrun");
   a_grid_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (({1'b0, i_ff} + {1'b0, j_ff}) <= (STEPS_W+1)'(GRID_STEPS)))
      else $error("grid point outside face");
   a_load_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD && !sts.out_busy) |=> (state_ff == S_IDLE))
      else $error("result load did not return to idle");
   a_sweep_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPDATE && i_ff == STEPS_W'(GRID_STEPS)) |=> (state_ff == S_IDLE))
      else $error("sweep did not end after last grid point");
`endif

endmodule

// ===== bench/testbench.sv =====
// testbench: self-checking bench for eikonal_tet_local_update_top
// depends on etlu_pkg and the block's rtl; predicts each finish result in sv
module testbench;
   import etlu_pkg::*;

   typedef struct {
      logic [1:0]  op;
      logic [1:0]  slot;
      logic [31:0] x, y, z, t;
      bit          typed;
      logic [39:0] et;
      logic        ef;
   } item_type;

   typedef struct {
      logic [39:0] best;
      logic        found;
   } result_type;

   localparam logic [39:0] ALL_ONES = {BEST_W{1'b1}};
   localparam int IDLE_LIMIT = 60000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_opcode = OP_FINISH;
   logic [1:0]         req_corner = 2'd0;
   logic signed [31:0] req_pos_x = '0;
   logic signed [31:0] req_pos_y = '0;
   logic signed [31:0] req_pos_z = '0;
   logic [31:0]        req_arrival_time = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [39:0]        rsp_best_time;
   logic               rsp_found;

   eikonal_tet_local_update_top u_top (.*);

   always #1 clock = ~clock;

   // predicted block state
   int signed   tgt_pt[3];
   int signed   cell_pt[9];
   int unsigned cell_tm[3];
   logic [39:0] min_scaled;
   bit          cell_seen;
   bit          slot_written[3];

   result_type  pending_results[$];
   int          errors = 0;
   int          results_seen = 0;
   int          burst_left = 0;
   item_type    rows[$];

   task automatic report(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
   endtask

   function automatic longint unsigned floor_root(input logic [127:0] v);
      logic [127:0] r;
      logic [127:0] c;
      r = '0;
      for (int b = 42; b >= 0; b--) begin
         c = r | (128'd1 << b);
         if (c * c <= v) r = c;
      end
      return r[63:0];
   endfunction

   function automatic void sweep_cell();
      longint      d;
      longint unsigned mag, s;
      logic [127:0] sq, m;
      int n, k;
      n = GRID_STEPS;
      for (int i = 0; i <= n; i++) begin
         for (int j = 0; j <= n - i; j++) begin
            k = n - i - j;
            sq = '0;
            for (int ax = 0; ax < 3; ax++) begin
               d = longint'(n) * tgt_pt[ax] - (longint'(i) * cell_pt[ax]
                   + longint'(j) * cell_pt[3 + ax] + longint'(k) * cell_pt[6 + ax]);
               mag = d < 0 ? -d : d;
               m = mag;
               sq = sq + m * m;
            end
            s = longint'(i) * cell_tm[0] + longint'(j) * cell_tm[1]
                + longint'(k) * cell_tm[2] + floor_root(sq);
            if (s > ALL_ONES) s = ALL_ONES;
            if (s < min_scaled) min_scaled = s[39:0];
         end
      end
   endfunction

   function automatic void apply_item(input item_type r);
      result_type e;
      case (r.op)
         OP_TARGET: begin
            tgt_pt[0] = r.x;
            tgt_pt[1] = r.y;
            tgt_pt[2] = r.z;
            min_scaled = ALL_ONES;
            cell_seen = 0;
         end
         OP_CORNER: begin
            if (r.slot <= SLOT_LAST) begin
               cell_pt[r.slot * 3]     = r.x;
               cell_pt[r.slot * 3 + 1] = r.y;
               cell_pt[r.slot * 3 + 2] = r.z;
               cell_tm[r.slot] = r.t;
               slot_written[r.slot] = 1;
               if (r.slot == SLOT_LAST) begin
                  sweep_cell();
                  cell_seen = 1;
               end
            end
         end
         OP_FINISH: begin
            if (cell_seen) begin
               e.best = min_scaled / GRID_STEPS;
               e.found = 1'b1;
            end else begin
               e.best = ALL_ONES;
               e.found = 1'b0;
            end
            if (r.typed) begin
               e.best = r.et;
               e.found = r.ef;
            end
            pending_results.push_back(e);
         end
         default: ;
      endcase
   endfunction

   task automatic send_item(input item_type r);
      int gap;
      req_valid <= 1'b1;
      req_opcode <= r.op;
      req_corner <= r.slot;
      req_pos_x <= r.x;
      req_pos_y <= r.y;
      req_pos_z <= r.z;
      req_arrival_time <= r.t;
      do @(posedge clock); while (req_stall);
      apply_item(r);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 15);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   function automatic item_type mk(input logic [1:0] op, input logic [1:0] slot,
                                   input logic [31:0] x, input logic [31:0] y,
                                   input logic [31:0] z, input logic [31:0] t);
      item_type r;
      r.op = op; r.slot = slot; r.x = x; r.y = y; r.z = z; r.t = t;
      r.typed = 0; r.et = '0; r.ef = 1'b0;
      return r;
   endfunction

   function automatic item_type mk_fin(input logic [39:0] et, input logic ef);
      item_type r;
      r = mk(OP_FINISH, 2'd0, '0, '0, '0, '0);
      r.typed = 1; r.et = et; r.ef = ef;
      return r;
   endfunction

   function automatic logic [31:0] rnd_coord(input logic [31:0] base);
      case ($urandom_range(0, 2))
         0: return $urandom;
         1: return base + $signed($urandom_range(0, 2000000)) - 1000000;
         default: return base + $signed($urandom_range(0, 2000)) - 1000;
      endcase
   endfunction

   function automatic logic [31:0] rnd_time();
      return $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 20);
   endfunction

   function automatic item_type rnd_noise();
      item_type r;
      r = mk(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), $urandom, $urandom,
             $urandom, $urandom);
      if (r.op == OP_CORNER && r.slot == SLOT_LAST
          && !(slot_written[0] && slot_written[1]))
         r.slot = 2'd3;
      return r;
   endfunction

   // receiver stall pattern with one long hold-off
   initial begin
      int mode;
      bit held;
      held = 0;
      @(negedge reset);
      forever begin
         mode = $urandom_range(0, 2);
         repeat ($urandom_range(50, 400)) begin
            @(posedge clock);
            if (!held && results_seen >= 20) begin
               held = 1;
               rsp_stall <= 1'b1;
               repeat (5000) @(posedge clock);
            end
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= 1'($urandom_range(0, 1));
               default: rsp_stall <= $urandom_range(0, 9) != 0;
            endcase
         end
      end
   end

   // result checking
   always @(posedge clock) begin
      result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            report("result beat with nothing expected");
         end else begin
            e = pending_results.pop_front();
            if (rsp_best_time !== e.best)
               report($sformatf("best_time %h expected %h", rsp_best_time, e.best));
            if (rsp_found !== e.found)
               report($sformatf("found %b expected %b", rsp_found, e.found));
         end
      end
   end

   // watchdog on cycles without any accepted beat
   initial begin
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle = 0;
         else idle++;
         if (idle >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", idle);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      item_type r;
      logic [31:0] bx, by, bz;
      int sent, cells;
      for (int q = 0; q < 3; q++) begin
         tgt_pt[q] = 0; cell_tm[q] = 0; slot_written[q] = 0;
      end
      for (int q = 0; q < 9; q++) cell_pt[q] = 0;
      min_scaled = ALL_ONES;
      cell_seen = 0;

      rows.push_back(mk_fin(ALL_ONES, 1'b0));
      rows.push_back(mk(OP_TARGET, 2'd3, '0, '0, '0, 32'hffffffff));
      rows.push_back(mk_fin(ALL_ONES, 1'b0));
      rows.push_back(mk(OP_CORNER, 2'd0, '0, '0, '0, '0));
      rows.push_back(mk(OP_CORNER, 2'd1, '0, '0, '0, '0));
      rows.push_back(mk(OP_CORNER, 2'd2, '0, '0, '0, '0));
      rows.push_back(mk_fin(40'd0, 1'b1));
      rows.push_back(mk_fin(40'd0, 1'b1));
      rows.push_back(mk(OP_CORNER, 2'd3, 32'h7fffffff, 32'h80000000, '1, '1));
      rows.push_back(mk(2'd3, 2'd2, '1, '1, '1, '1));
      rows.push_back(mk_fin(40'd0, 1'b1));
      rows.push_back(mk(OP_TARGET, 2'd0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, '0));
      rows.push_back(mk(OP_CORNER, 2'd0, 32'h80000000, 32'h80000000, 32'h80000000, '1));
      rows.push_back(mk(OP_CORNER, 2'd1, 32'h80000000, 32'h7fffffff, 32'h80000000, '1));
      rows.push_back(mk(OP_CORNER, 2'd2, 32'h80000000, 32'h80000000, 32'h7fffffff, '1));
      rows.push_back(mk(OP_FINISH, 2'd0, '0, '0, '0, '0));
      rows.push_back(mk(OP_TARGET, 2'd1, 32'h80000000, 32'h80000000, 32'h80000000, '0));
      rows.push_back(mk(OP_CORNER, 2'd0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, '0));
      rows.push_back(mk(OP_CORNER, 2'd1, 32'h00010000, 32'hffff0000, 32'h0, 32'h1));
      rows.push_back(mk(OP_CORNER, 2'd2, 32'h80000000, 32'h7fffffff, 32'h1, 32'h80000000));
      rows.push_back(mk(OP_FINISH, 2'd0, '0, '0, '0, '0));
      rows.push_back(mk(OP_TARGET, 2'd0, '0, '0, '0, '0));
      rows.push_back(mk_fin(ALL_ONES, 1'b0));

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[n]) send_item(rows[n]);

      sent = 0;
      while (sent < 1500) begin
         if (sent > 700 && sent < 720) begin
            req_valid <= 1'b0;
            wait (pending_results.size() == 0);
            @(posedge clock);
         end
         if ($urandom_range(0, 4) == 0) begin
            send_item(rnd_noise());
            sent++;
            continue;
         end
         bx = $urandom; by = $urandom; bz = $urandom;
         if ($urandom_range(0, 1)) begin
            bx = $signed(bx) >>> 8; by = $signed(by) >>> 8; bz = $signed(bz) >>> 8;
         end
         send_item(mk(OP_TARGET, 2'($urandom_range(0, 3)), bx, by, bz, $urandom));
         sent++;
         cells = $urandom_range(0, 2);
         repeat (cells) begin
            for (int s = 0; s <= SLOT_LAST; s++) begin
               r = mk(OP_CORNER, 2'(s), rnd_coord(bx), rnd_coord(by), rnd_coord(bz),
                      rnd_time());
               send_item(r);
               sent++;
               if (s < SLOT_LAST && $urandom_range(0, 9) == 0) begin
                  send_item(rnd_noise());
                  sent++;
               end
            end
         end
         repeat ($urandom_range(1, 2)) begin
            send_item(mk(OP_FINISH, 2'($urandom_range(0, 3)), $urandom, $urandom,
                         $urandom, $urandom));
            sent++;
         end
      end
      req_valid <= 1'b0;

      wait (pending_results.size() == 0);
      repeat (200) @(posedge clock);
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/etlu_pkg.sv
sv/etlu_dp.sv
sv/etlu_ctrl.sv
sv/eikonal_tet_local_update_top.sv
bench/testbench.sv
